FILE: hdl/mrf_pkg.sv
package mrf_pkg;

	localparam logic [7:0] MaxPayload = 8'd247;
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	typedef struct packed {
		logic        kind;
		logic [7:0]  slave_address;
		logic [7:0]  func_code;
		logic [15:0] start_register;
		logic [15:0] register_count;
		logic [7:0]  payload_length;
		logic [7:0]  payload_byte;
	} req_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_end;
	} tx_item_t;

	typedef enum logic {
		KIND_HEADER = 1'b0,
		KIND_DATA   = 1'b1
	} kind_t;

	typedef enum logic {
		OP_HEADER = 1'b0,
		OP_DATA   = 1'b1
	} op_t;

	// one queued command for the serialiser
	typedef struct packed {
		op_t         op;
		logic        with_crc;
		logic [7:0]  addr;
		logic [7:0]  func;
		logic [15:0] start;
		logic [15:0] count;
		logic [7:0]  len;
		logic [7:0]  data;
	} cmd_t;

	// reflected crc-16/modbus, one byte in eight bit steps
	function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: hdl/mrf_front.sv
module mrf_front import mrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      push_valid,
	input  logic      push_ready,
	output cmd_t      push_cmd
);

	logic       open_q;
	logic [7:0] remaining_q;
	logic [7:0] len_sat;
	logic       accept;
	logic       data_ok;

	assign req_ready = push_ready;
	assign accept    = req_valid && req_ready;
	assign len_sat   = (req.payload_length > MaxPayload) ? MaxPayload : req.payload_length;
	assign data_ok   = open_q && (remaining_q != 8'd0);

	always_comb begin
		push_cmd.addr  = req.slave_address;
		push_cmd.func  = req.func_code;
		push_cmd.start = req.start_register;
		push_cmd.count = req.register_count;
		push_cmd.len   = len_sat;
		push_cmd.data  = req.payload_byte;
		if (kind_t'(req.kind) == KIND_HEADER) begin
			push_cmd.op       = OP_HEADER;
			push_cmd.with_crc = (len_sat == 8'd0);
			push_valid        = req_valid;
		end else begin
			push_cmd.op       = OP_DATA;
			push_cmd.with_crc = (remaining_q == 8'd1);
			// payload with no open frame is dropped here
			push_valid        = req_valid && data_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			remaining_q <= 8'd0;
		end else if (accept) begin
			if (kind_t'(req.kind) == KIND_HEADER) begin
				open_q      <= (len_sat != 8'd0);
				remaining_q <= len_sat;
			end else if (data_ok) begin
				remaining_q <= remaining_q - 8'd1;
				if (remaining_q == 8'd1) begin
					open_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: hdl/mrf_queue.sv
module mrf_queue import mrf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic head_valid,
	input  logic pop,
	output cmd_t head_cmd
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] Full = CntW'(DEPTH);

	cmd_t            store_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != Full);
	assign head_valid = (count_q != '0);
	assign head_cmd   = store_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/mrf_back.sv
module mrf_back import mrf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  cmd_t     head_cmd,
	output logic     pop,
	output logic     tx_valid,
	input  logic     tx_ready,
	output tx_item_t tx
);

	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic        tx_valid_q;
	tx_item_t    tx_q;

	logic        advance;
	logic        emit;
	logic [7:0]  cur_byte;
	logic        is_crc;
	logic        is_end;
	logic        is_last;
	logic [15:0] crc_base;
	logic [15:0] crc_next;

	assign advance  = !tx_valid_q || tx_ready;
	assign emit     = advance && head_valid;
	assign tx_valid = tx_valid_q;
	assign tx       = tx_q;

	always_comb begin
		cur_byte = 8'h00;
		is_crc   = 1'b0;
		is_end   = 1'b0;
		is_last  = 1'b0;
		if (head_cmd.op == OP_HEADER) begin
			case (idx_q)
				4'd0: cur_byte = head_cmd.addr;
				4'd1: cur_byte = head_cmd.func;
				4'd2: cur_byte = head_cmd.start[15:8];
				4'd3: cur_byte = head_cmd.start[7:0];
				4'd4: cur_byte = head_cmd.count[15:8];
				4'd5: cur_byte = head_cmd.count[7:0];
				4'd6: begin
					cur_byte = head_cmd.len;
					is_last  = !head_cmd.with_crc;
				end
				4'd7: begin
					cur_byte = crc_q[7:0];
					is_crc   = 1'b1;
				end
				4'd8: begin
					cur_byte = crc_q[15:8];
					is_crc   = 1'b1;
					is_end   = 1'b1;
					is_last  = 1'b1;
				end
				default: cur_byte = 8'h00;
			endcase
		end else begin
			case (idx_q)
				4'd0: begin
					cur_byte = head_cmd.data;
					is_last  = !head_cmd.with_crc;
				end
				4'd1: begin
					cur_byte = crc_q[7:0];
					is_crc   = 1'b1;
				end
				4'd2: begin
					cur_byte = crc_q[15:8];
					is_crc   = 1'b1;
					is_end   = 1'b1;
					is_last  = 1'b1;
				end
				default: cur_byte = 8'h00;
			endcase
		end
	end

	// a header restarts the crc at its first byte
	assign crc_base = (head_cmd.op == OP_HEADER && idx_q == 4'd0) ? CrcInit : crc_q;
	assign crc_next = is_crc ? crc_q : crc_update(crc_base, cur_byte);
	assign pop      = emit && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= 4'd0;
			crc_q      <= CrcInit;
			tx_valid_q <= 1'b0;
		end else if (advance) begin
			tx_valid_q <= head_valid;
			if (head_valid) begin
				crc_q <= crc_next;
				idx_q <= is_last ? 4'd0 : idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tx_q.tx_byte   <= cur_byte;
			tx_q.frame_end <= is_end;
		end
	end

endmodule

FILE: hdl/modbus_request_framer_crc16.sv
// an accepted item is written into the request queue, and its bytes are then registered onto tx
// throughput: one frame byte per cycle while tx_ready allows; a header is 7 bytes, 9 with
// zero payload, a payload byte 1 byte, 3 when last; the output byte serialiser sets this
// the request queue of QUEUE_DEPTH commands lets requests be taken while bytes drain
// reset is asynchronous: queue emptied, no frame open, crc back to 0xffff
module modbus_request_framer_crc16 import mrf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      tx_valid,
	input  logic      tx_ready,
	output tx_item_t  tx
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	mrf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	mrf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.head_valid (head_valid),
		.pop        (pop),
		.head_cmd   (head_cmd)
	);

	mrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.tx_valid   (tx_valid),
		.tx_ready   (tx_ready),
		.tx         (tx)
	);

endmodule

FILE: tb/mrf_frame_checker.sv
`timescale 1ns / 100ps

module mrf_frame_checker import mrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_item_t req,
	input  logic      tx_valid,
	input  logic      tx_ready,
	input  tx_item_t  tx,
	input  logic      check_done,
	output int        mismatch_count,
	output int        bytes_pending,
	output int        bytes_checked
);

	tx_item_t    expected_bytes[$];
	logic [15:0] frame_crc;
	logic [7:0]  payload_left;
	logic        frame_active;
	logic        leftover_reported;

	// bit-serial form of the reflected crc-16, lsb of the data byte first
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CrcPoly;
			end
		end
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 50) begin
			$display("%0t ns mismatch: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	task automatic queue_byte(input logic [7:0] b);
		tx_item_t e;
		e.tx_byte = b;
		e.frame_end = 1'b0;
		frame_crc = crc16_next(frame_crc, b);
		expected_bytes.push_back(e);
	endtask

	// crc goes out low byte first and is not folded into itself
	task automatic queue_crc();
		tx_item_t e;
		e.tx_byte = frame_crc[7:0];
		e.frame_end = 1'b0;
		expected_bytes.push_back(e);
		e.tx_byte = frame_crc[15:8];
		e.frame_end = 1'b1;
		expected_bytes.push_back(e);
		frame_active = 1'b0;
		payload_left = '0;
	endtask

	task automatic predict_frame_bytes(input req_item_t it);
		logic [7:0] len;
		if (kind_t'(it.kind) == KIND_HEADER) begin
			len = (it.payload_length > MaxPayload) ? MaxPayload : it.payload_length;
			// a header while a frame is open simply drops the old frame
			frame_crc = CrcInit;
			queue_byte(it.slave_address);
			queue_byte(it.func_code);
			queue_byte(it.start_register[15:8]);
			queue_byte(it.start_register[7:0]);
			queue_byte(it.register_count[15:8]);
			queue_byte(it.register_count[7:0]);
			queue_byte(len);
			if (len == 0) begin
				queue_crc();
			end else begin
				payload_left = len;
				frame_active = 1'b1;
			end
		end else if (frame_active && payload_left != 0) begin
			queue_byte(it.payload_byte);
			payload_left = payload_left - 8'd1;
			if (payload_left == 0) begin
				queue_crc();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tx_item_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			frame_crc = CrcInit;
			payload_left = '0;
			frame_active = 1'b0;
			leftover_reported = 1'b0;
			mismatch_count = 0;
			bytes_pending = 0;
			bytes_checked = 0;
		end else begin
			if (req_valid && req_ready) begin
				predict_frame_bytes(req);
			end
			if (tx_valid && tx_ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected tx byte %02h frame_end %b",
						tx.tx_byte, tx.frame_end));
				end else begin
					want = expected_bytes.pop_front();
					if (tx.tx_byte !== want.tx_byte) begin
						report_mismatch($sformatf("tx_byte %02h, wanted %02h (byte %0d)",
							tx.tx_byte, want.tx_byte, bytes_checked));
					end
					if (tx.frame_end !== want.frame_end) begin
						report_mismatch($sformatf("frame_end %b, wanted %b (byte %0d)",
							tx.frame_end, want.frame_end, bytes_checked));
					end
					bytes_checked++;
				end
			end
			if (check_done && !leftover_reported) begin
				leftover_reported = 1'b1;
				if (expected_bytes.size() != 0) begin
					report_mismatch($sformatf("%0d expected bytes never came out",
						expected_bytes.size()));
				end
			end
			bytes_pending = expected_bytes.size();
		end
	end

endmodule

FILE: tb/modbus_request_framer_crc16_tb.sv
`timescale 1ns / 100ps

module modbus_request_framer_crc16_tb;
	import mrf_pkg::*;

	localparam int ItemTarget = 450;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      tx_valid;
	logic      tx_ready;
	tx_item_t  tx;
	logic      check_done;

	int mismatch_count;
	int bytes_pending;
	int bytes_checked;

	int items_sent;
	int frames_sent;
	int stray_sent;
	int burst_left;

	modbus_request_framer_crc16 u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.tx_valid (tx_valid),
		.tx_ready (tx_ready),
		.tx       (tx)
	);

	mrf_frame_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.tx_valid      (tx_valid),
		.tx_ready      (tx_ready),
		.tx            (tx),
		.check_done    (check_done),
		.mismatch_count(mismatch_count),
		.bytes_pending (bytes_pending),
		.bytes_checked (bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver: changing stall patterns plus one long hold-off to back the block up
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int cyc;
		bit hold_done;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		cyc = 0;
		hold_done = 1'b0;
		tx_ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (!hold_done && items_sent >= 120) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				tx_ready <= 1'b0;
			end else begin
				case (mode)
					0: tx_ready <= 1'b1;
					1: tx_ready <= 1'($urandom_range(0, 1));
					2: tx_ready <= (cyc % 5) != 0;
					default: tx_ready <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	task automatic send_item(input req_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic send_header(input logic [7:0] addr, input logic [7:0] func,
		input logic [15:0] start, input logic [15:0] count, input logic [7:0] len);
		req_item_t it;
		it.kind = KIND_HEADER;
		it.slave_address = addr;
		it.func_code = func;
		it.start_register = start;
		it.register_count = count;
		it.payload_length = len;
		it.payload_byte = 8'($urandom);
		send_item(it);
		items_sent++;
		frames_sent++;
	endtask

	// header fields are junk on a data transaction; the block must ignore them
	task automatic send_data(input logic [7:0] b, input bit in_frame);
		req_item_t it;
		it.kind = KIND_DATA;
		it.slave_address = 8'($urandom);
		it.func_code = 8'($urandom);
		it.start_register = 16'($urandom);
		it.register_count = 16'($urandom);
		it.payload_length = 8'($urandom);
		it.payload_byte = b;
		send_item(it);
		if (in_frame) begin
			items_sent++;
		end else begin
			stray_sent++;
		end
	endtask

	initial begin
		int sel;
		int len;
		int frame_len;
		int n_data;
		int wait_cycles;
		bit frame_closed;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		check_done <= 1'b0;
		items_sent = 0;
		frames_sent = 0;
		stray_sent = 0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray byte, extremes, truncated and saturated frames
		send_data(8'hA5, 1'b0);
		send_header(8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00);
		send_header(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_data(8'h00, 1'b1);
		send_data(8'hFF, 1'b1);
		send_header(8'h01, 8'h03, 16'h0000, 16'h000A, 8'h00);
		send_header(8'h11, 8'h10, 16'h006B, 16'h0003, 8'h01);
		send_data(8'h5A, 1'b1);
		send_header(8'hF7, 8'h06, 16'h1234, 16'hABCD, 8'h03);
		send_data(8'hFF, 1'b1);
		send_data(8'h00, 1'b1);
		send_data(8'h81, 1'b1);
		send_data(8'h3C, 1'b0);
		send_header(8'h55, 8'hAA, 16'h5555, 16'hAAAA, 8'hF8);
		send_data(8'h11, 1'b1);
		send_header(8'h7F, 8'h10, 16'h8000, 16'h0001, 8'h02);
		send_data(8'h80, 1'b1);
		send_data(8'h01, 1'b1);
		frame_closed = 1'b1;

		// random: mostly whole frames, some cut short, some stray bytes between frames
		while (items_sent < ItemTarget) begin
			if ($urandom_range(0, 99) < 8) begin
				if (frame_closed) begin
					send_data(8'($urandom), 1'b0);
				end
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 10) begin
					len = 0;
				end else if (sel < 80) begin
					len = $urandom_range(1, 8);
				end else if (sel < 97) begin
					len = $urandom_range(9, 40);
				end else if (sel < 99) begin
					len = $urandom_range(248, 255);
				end else begin
					len = $urandom_range(200, 247);
				end
				frame_len = (len > MaxPayload) ? MaxPayload : len;
				if (len > MaxPayload) begin
					n_data = $urandom_range(0, 10);
				end else if (frame_len > 0 && $urandom_range(0, 9) == 0) begin
					n_data = $urandom_range(0, frame_len - 1);
				end else begin
					n_data = frame_len;
				end
				send_header(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
					len[7:0]);
				for (int i = 0; i < n_data; i++) begin
					send_data(8'($urandom), 1'b1);
				end
				frame_closed = (n_data == frame_len);
			end
		end
		req_valid <= 1'b0;

		@(posedge clk);
		wait_cycles = 0;
		while (bytes_pending != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		check_done <= 1'b1;
		repeat (2) @(posedge clk);

		$display("run covered %0d requests in %0d frames and %0d ignored stray bytes",
			items_sent, frames_sent, stray_sent);
		$display("%0d frame bytes compared, %0d mismatches", bytes_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
